// ----- hdl/plof_pkg.sv -----
// ----------------------------------------------------------------------------
// plof_pkg: shared types and constants of the price level order queue
// Operation and status codes, field widths and the command broadcast
// from the controller to every queue cell.
// ----------------------------------------------------------------------------
`default_nettype none

package plof_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;
    localparam int QUEUE_DEPTH_D = 64;
    localparam logic [DATA_W-1:0] LEVEL_PRICE_RST = 32'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_REDUCE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_EXCEEDS   = 3'd6
    } status_t;

    // Broadcast to all cells during the execute cycle
    typedef struct packed {
        logic              load;   // append the item at the first free cell
        logic              shift;  // close the gap behind the removed order
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] qty;    // added quantity, or reduce amount
        logic              side;
    } cell_cmd_t;

    // Contents one cell shows to its neighbor and to the controller
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] qty;
        logic              side;
    } cell_data_t;

endpackage

`default_nettype wire

// ----- hdl/plof_cell.sv -----
// ----------------------------------------------------------------------------
// plof_cell: one slot of the order queue
// Holds one resting order, compares its id on item accept, takes part in
// the oldest-match chain and shifts in its neighbor's order on a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module plof_cell (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire plof_pkg::cell_cmd_t     cmd,
    input  wire                          red_en,
    input  wire                          cmp_en,
    input  wire [plof_pkg::DATA_W-1:0]   cmp_id,
    input  wire                          prev_valid,
    input  wire                          hit_in,
    input  wire plof_pkg::cell_data_t    nxt,
    output plof_pkg::cell_data_t         cur,
    output logic                         hit_out,
    output logic                         first_hit,
    output logic [plof_pkg::DATA_W-1:0]  sel_qty
);

    logic                        valid_reg;
    logic [plof_pkg::DATA_W-1:0] id_reg;
    logic [plof_pkg::DATA_W-1:0] qty_reg;
    logic                        side_reg;
    logic                        match_reg;
    logic                        load_en;
    logic                        shift_en;

    // Oldest-match chain: this cell is the first hit if no earlier cell hit
    assign hit_out   = hit_in | match_reg;
    assign first_hit = match_reg & ~hit_in;
    assign sel_qty   = first_hit ? qty_reg : '0;

    assign load_en  = cmd.load & ~valid_reg & prev_valid;
    assign shift_en = cmd.shift & hit_out;

    assign cur.valid = valid_reg;
    assign cur.id    = id_reg;
    assign cur.qty   = qty_reg;
    assign cur.side  = side_reg;

    // Latch id match against the incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (cmp_en) begin
            match_reg <= valid_reg & (cmp_id == id_reg);
        end
    end

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= nxt.valid;
        end else if (load_en) begin
            valid_reg <= 1'b1;
        end
    end

    // Update the order payload
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            id_reg   <= nxt.id;
            qty_reg  <= nxt.qty;
            side_reg <= nxt.side;
        end else if (load_en) begin
            id_reg   <= cmd.id;
            qty_reg  <= cmd.qty;
            side_reg <= cmd.side;
        end else if (red_en) begin
            qty_reg  <= qty_reg - cmd.qty;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/price_level_order_fifo_top.sv -----
// ----------------------------------------------------------------------------
// price_level_order_fifo_top: time-priority order queue of one price level
// Controller, level registers and a chain of queue cells.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ channel (valid/ready). Each item is an add, a
//   remove by id or a reduce of the front order, and gives exactly one result
//   on the m_ channel: status, level total, empty flag and front order. The
//   user must write the level price over the cfg_ channel while the block is
//   idle; the block itself does not enforce this.
// Operation (s_ready is low while in S_EXEC):
//   On accept all cells compare their ids in parallel and latch a match; the
//   oldest-match chain across the cells sets the execute-cycle path. In
//   S_EXEC, once the output register is free, the controller checks the
//   operation, the cells append, shift or reduce, the result is registered.
// Reset:
//   aresetn (synchronous, active low) empties the queue, clears the total and
//   sets the level price to 1.
// Stall:
//   The result waits in the output register while m_ready is low; one more
//   item is accepted meanwhile and held until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_order_fifo_top #(
    parameter int QUEUE_DEPTH = plof_pkg::QUEUE_DEPTH_D
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // configuration
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [plof_pkg::DATA_W-1:0]     cfg_data,
    // input items
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire [plof_pkg::OP_W-1:0]       s_operation,
    input  wire [plof_pkg::DATA_W-1:0]     s_order_id,
    input  wire                            s_order_side,
    input  wire                            s_order_is_limit,
    input  wire [plof_pkg::DATA_W-1:0]     s_order_price,
    input  wire [plof_pkg::DATA_W-1:0]     s_quantity,
    // result items
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [plof_pkg::STATUS_W-1:0]  m_status,
    output logic [plof_pkg::DATA_W-1:0]    m_total_qty,
    output logic                           m_is_empty,
    output logic [plof_pkg::DATA_W-1:0]    m_front_id,
    output logic [plof_pkg::DATA_W-1:0]    m_front_qty,
    output logic                           m_front_side
);

    localparam int DW    = plof_pkg::DATA_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0]     level_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DW-1:0]     sum_reg, sum_next;

    plof_pkg::op_t     op_reg;
    logic [DW-1:0]     id_reg;
    logic              side_reg;
    logic              limit_reg;
    logic [DW-1:0]     price_reg;
    logic [DW-1:0]     qty_reg;

    plof_pkg::cell_cmd_t  cmd;
    plof_pkg::cell_data_t cell_q   [QUEUE_DEPTH];
    logic [DW-1:0]        cell_sel [QUEUE_DEPTH];
    logic                 hit_chain [QUEUE_DEPTH+1];
    logic                 first0;
    logic                 accept;
    logic                 exec_done;
    logic [DW-1:0]        rem_qty;
    logic [DW:0]          sum_wide;

    plof_pkg::status_t    status;
    logic                 add_ok, rem_ok, red_ok;
    logic [DW-1:0]        front_id, front_qty;
    logic                 front_side, front_valid;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid & s_ready;
    assign exec_done = (state_reg == S_EXEC) & (~m_valid | m_ready);

    // Level price register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= plof_pkg::LEVEL_PRICE_RST;
        end else if (cfg_valid) begin
            level_reg <= cfg_data;
        end
    end

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= plof_pkg::op_t'(s_operation);
            id_reg    <= s_order_id;
            side_reg  <= s_order_side;
            limit_reg <= s_order_is_limit;
            price_reg <= s_order_price;
            qty_reg   <= s_quantity;
        end
    end

    // Broadcast command to the cells
    assign cmd.load  = exec_done & add_ok;
    assign cmd.shift = exec_done & rem_ok;
    assign cmd.id    = id_reg;
    assign cmd.qty   = qty_reg;
    assign cmd.side  = side_reg;

    assign hit_chain[0] = 1'b0;

    // Chain of queue cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        plof_pkg::cell_data_t nxt_data;
        logic                 prev_v;
        logic                 first_h;

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nxt_data = '0;
        end else begin : g_mid
            assign nxt_data = cell_q[i+1];
        end

        if (i == 0) begin : g_head
            assign prev_v = 1'b1;
            assign first0 = first_h;
        end else begin : g_body
            assign prev_v = cell_q[i-1].valid;
        end

        plof_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .red_en     ((i == 0) ? (exec_done & red_ok) : 1'b0),
            .cmp_en     (accept),
            .cmp_id     (s_order_id),
            .prev_valid (prev_v),
            .hit_in     (hit_chain[i]),
            .nxt        (nxt_data),
            .cur        (cell_q[i]),
            .hit_out    (hit_chain[i+1]),
            .first_hit  (first_h),
            .sel_qty    (cell_sel[i])
        );
    end

    // Gather the quantity of the removed order (at most one cell selects)
    always_comb begin
        rem_qty = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            rem_qty = rem_qty | cell_sel[k];
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {1'b0, qty_reg};

    // Check the operation
    always_comb begin
        status = plof_pkg::ST_INVALID;
        add_ok = 1'b0;
        rem_ok = 1'b0;
        red_ok = 1'b0;
        unique case (op_reg)
            plof_pkg::OP_ADD: begin
                if (!limit_reg || qty_reg == '0 || level_reg == '0 ||
                    price_reg != level_reg) begin
                    status = plof_pkg::ST_INVALID;
                end else if (sum_wide[DW]) begin
                    status = plof_pkg::ST_OVERFLOW;
                end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                    status = plof_pkg::ST_FULL;
                end else begin
                    status = plof_pkg::ST_OK;
                    add_ok = 1'b1;
                end
            end
            plof_pkg::OP_REMOVE: begin
                if (hit_chain[QUEUE_DEPTH]) begin
                    status = plof_pkg::ST_OK;
                    rem_ok = 1'b1;
                end else begin
                    status = plof_pkg::ST_NOT_FOUND;
                end
            end
            plof_pkg::OP_REDUCE: begin
                if (!cell_q[0].valid) begin
                    status = plof_pkg::ST_EMPTY;
                end else if (qty_reg > cell_q[0].qty) begin
                    status = plof_pkg::ST_EXCEEDS;
                end else begin
                    status = plof_pkg::ST_OK;
                    red_ok = 1'b1;
                end
            end
            default: begin
                status = plof_pkg::ST_INVALID;
            end
        endcase
    end

    // Next total, count and front order
    always_comb begin
        sum_next    = sum_reg;
        count_next  = count_reg;
        front_valid = cell_q[0].valid;
        front_id    = cell_q[0].id;
        front_qty   = cell_q[0].qty;
        front_side  = cell_q[0].side;
        if (add_ok) begin
            sum_next   = sum_wide[DW-1:0];
            count_next = count_reg + CNT_W'(1);
            if (!cell_q[0].valid) begin
                front_valid = 1'b1;
                front_id    = id_reg;
                front_qty   = qty_reg;
                front_side  = side_reg;
            end
        end else if (rem_ok) begin
            sum_next   = sum_reg - rem_qty;
            count_next = count_reg - CNT_W'(1);
            if (first0) begin
                front_valid = cell_q[1].valid;
                front_id    = cell_q[1].id;
                front_qty   = cell_q[1].qty;
                front_side  = cell_q[1].side;
            end
        end else if (red_ok) begin
            sum_next  = sum_reg - qty_reg;
            front_qty = cell_q[0].qty - qty_reg;
        end
    end

    // Level total and order count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (exec_done) begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (exec_done) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done) begin
            m_status     <= status;
            m_total_qty  <= sum_next;
            m_is_empty   <= ~front_valid;
            m_front_id   <= front_valid ? front_id   : '0;
            m_front_qty  <= front_valid ? front_qty  : '0;
            m_front_side <= front_valid ? front_side : 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_price_level_order_fifo_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_price_level_order_fifo_top: self-checking bench of the price level queue
// Sends adds, removes, reduces and the unused code over the s_ channel. A
// behavioral copy of the level predicts every result, and the m_ channel is
// checked in order against it. The level price changes between phases while
// the block is idle. Both sides idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------

module tb_price_level_order_fifo_top;

    localparam int DATA_W      = plof_pkg::DATA_W;
    localparam int OP_W        = plof_pkg::OP_W;
    localparam int STATUS_W    = plof_pkg::STATUS_W;
    localparam int DEPTH       = plof_pkg::QUEUE_DEPTH_D;
    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 5;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE_CYC  = 4;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD   = 120;
    localparam int HOLD_AT     = 850;
    localparam int PHASES      = 8;
    localparam int HALF_PHASE  = 100;
    localparam int FILL_ADDS   = 70;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef struct {
        plof_pkg::op_t     op_code;
        logic [DATA_W-1:0] id;
        logic              side;
        logic              is_limit;
        logic [DATA_W-1:0] price;
        logic [DATA_W-1:0] qty;
    } order_item_t;

    typedef struct packed {
        plof_pkg::status_t status;
        logic [DATA_W-1:0] total;
        logic              empty;
        logic [DATA_W-1:0] front_id;
        logic [DATA_W-1:0] front_qty;
        logic              front_side;
    } level_report_t;

    typedef struct {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] qty;
        logic              side;
    } resting_order_t;

    // DUT ports
    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              cfg_valid        = 1'b0;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data         = '0;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_operation      = '0;
    logic [DATA_W-1:0] s_order_id       = '0;
    logic              s_order_side     = 1'b0;
    logic              s_order_is_limit = 1'b0;
    logic [DATA_W-1:0] s_order_price    = '0;
    logic [DATA_W-1:0] s_quantity       = '0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [DATA_W-1:0] m_total_qty;
    logic              m_is_empty;
    logic [DATA_W-1:0] m_front_id;
    logic [DATA_W-1:0] m_front_qty;
    logic              m_front_side;

    // Level copy kept by the bench
    resting_order_t    resting_book[$];
    logic [DATA_W-1:0] resting_total = '0;
    logic [DATA_W-1:0] price_copy    = plof_pkg::LEVEL_PRICE_RST;

    order_item_t       pending_orders[$];
    level_report_t     expected_reports[$];

    bit                full_rate    = 1'b0;
    int                tx_gap       = 0;
    int                rx_wait      = 0;
    int                reports_seen = 0;
    int                mismatches   = 0;
    int                idle_cycles  = 0;

    price_level_order_fifo_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_order_id       (s_order_id),
        .s_order_side     (s_order_side),
        .s_order_is_limit (s_order_is_limit),
        .s_order_price    (s_order_price),
        .s_quantity       (s_quantity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_total_qty      (m_total_qty),
        .m_is_empty       (m_is_empty),
        .m_front_id       (m_front_id),
        .m_front_qty      (m_front_qty),
        .m_front_side     (m_front_side)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Apply one item to the level copy and return the result it gives
    function automatic level_report_t apply_order(order_item_t it);
        level_report_t  rep;
        resting_order_t ord;
        int             hit;
        hit = -1;
        case (it.op_code)
            plof_pkg::OP_ADD: begin
                if (!it.is_limit || it.qty == '0 || price_copy == '0 ||
                    it.price != price_copy) begin
                    rep.status = plof_pkg::ST_INVALID;
                end else if (it.qty > ALL_ONES - resting_total) begin
                    rep.status = plof_pkg::ST_OVERFLOW;
                end else if (resting_book.size() >= DEPTH) begin
                    rep.status = plof_pkg::ST_FULL;
                end else begin
                    ord.id   = it.id;
                    ord.qty  = it.qty;
                    ord.side = it.side;
                    resting_book.insert(resting_book.size(), ord);
                    resting_total = resting_total + it.qty;
                    rep.status = plof_pkg::ST_OK;
                end
            end
            plof_pkg::OP_REMOVE: begin
                // oldest match wins
                foreach (resting_book[i]) begin
                    if (hit < 0 && resting_book[i].id == it.id) hit = i;
                end
                if (hit < 0) begin
                    rep.status = plof_pkg::ST_NOT_FOUND;
                end else begin
                    resting_total = resting_total - resting_book[hit].qty;
                    resting_book.delete(hit);
                    rep.status = plof_pkg::ST_OK;
                end
            end
            plof_pkg::OP_REDUCE: begin
                if (resting_book.size() == 0) begin
                    rep.status = plof_pkg::ST_EMPTY;
                end else if (it.qty > resting_book[0].qty) begin
                    rep.status = plof_pkg::ST_EXCEEDS;
                end else begin
                    resting_book[0].qty = resting_book[0].qty - it.qty;
                    resting_total = resting_total - it.qty;
                    rep.status = plof_pkg::ST_OK;
                end
            end
            default: begin
                rep.status = plof_pkg::ST_INVALID;
            end
        endcase
        rep.total = resting_total;
        if (resting_book.size() == 0) begin
            rep.empty      = 1'b1;
            rep.front_id   = '0;
            rep.front_qty  = '0;
            rep.front_side = 1'b0;
        end else begin
            rep.empty      = 1'b0;
            rep.front_id   = resting_book[0].id;
            rep.front_qty  = resting_book[0].qty;
            rep.front_side = resting_book[0].side;
        end
        return rep;
    endfunction

    // Random item: ids from a small pool so removes find their orders
    function automatic order_item_t make_random_order(int add_pct, int rem_pct);
        order_item_t it;
        int          pick;
        int          qsel;
        it.id       = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 23) : $urandom;
        it.side     = 1'($urandom_range(0, 1));
        it.is_limit = ($urandom_range(0, 19) != 0);
        it.price    = ($urandom_range(0, 11) != 0) ? price_copy : $urandom;
        qsel = $urandom_range(0, 19);
        if (qsel == 0)
            it.qty = '0;
        else if (qsel == 1)
            it.qty = $urandom;
        else if (qsel == 2)
            it.qty = ALL_ONES - $urandom_range(0, 255);
        else if (qsel < 10)
            it.qty = $urandom_range(1, 16);
        else
            it.qty = $urandom_range(1, 1000);
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
            it.op_code = plof_pkg::OP_ADD;
        end else if (pick < add_pct + rem_pct) begin
            it.op_code = plof_pkg::OP_REMOVE;
        end else if (pick < 98) begin
            it.op_code = plof_pkg::OP_REDUCE;
            if ($urandom_range(0, 3) != 0) it.qty = $urandom_range(0, 16);
        end else begin
            it.op_code = plof_pkg::OP_NONE;
        end
        return it;
    endfunction

    task automatic push_order(plof_pkg::op_t op, logic [DATA_W-1:0] id, logic side,
                              logic is_limit, logic [DATA_W-1:0] price,
                              logic [DATA_W-1:0] qty);
        order_item_t it;
        it.op_code  = op;
        it.id       = id;
        it.side     = side;
        it.is_limit = is_limit;
        it.price    = price;
        it.qty      = qty;
        pending_orders.insert(pending_orders.size(), it);
    endtask

    // Hold until every item is sent and every result is back, then settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_orders.size() != 0 || s_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_level_price(logic [DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        price_copy  = value;
    endtask

    // Driver: send pending items, predict each one on its accept edge
    always @(posedge aclk) begin : drive_orders
        order_item_t taken;
        order_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                taken.op_code  = plof_pkg::op_t'(s_operation);
                taken.id       = s_order_id;
                taken.side     = s_order_side;
                taken.is_limit = s_order_is_limit;
                taken.price    = s_order_price;
                taken.qty      = s_quantity;
                expected_reports.insert(expected_reports.size(), apply_order(taken));
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    s_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (pending_orders.size() != 0) begin
                    nxt = pending_orders.pop_front();
                    s_valid          <= 1'b1;
                    s_operation      <= nxt.op_code;
                    s_order_id       <= nxt.id;
                    s_order_side     <= nxt.side;
                    s_order_is_limit <= nxt.is_limit;
                    s_order_price    <= nxt.price;
                    s_quantity       <= nxt.qty;
                    tx_gap           <= full_rate ? 0 : $urandom_range(0, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge aclk) begin : check_reports
        level_report_t want;
        level_report_t got;
        int            wait_n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            wait_n = 0;
            if (m_valid && m_ready) begin
                reports_seen++;
                got.status     = plof_pkg::status_t'(m_status);
                got.total      = m_total_qty;
                got.empty      = m_is_empty;
                got.front_id   = m_front_id;
                got.front_qty  = m_front_qty;
                got.front_side = m_front_side;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result %0d: status=%0d total=%0d", reports_seen,
                                 got.status, got.total);
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("Mismatch at result %0d", reports_seen);
                            $display({"  expected status=%0d total=%0d empty=%0b",
                                      " id=%h qty=%0d side=%0b"},
                                     want.status, want.total, want.empty, want.front_id,
                                     want.front_qty, want.front_side);
                            $display({"  actual   status=%0d total=%0d empty=%0b",
                                      " id=%h qty=%0d side=%0b"},
                                     got.status, got.total, got.empty, got.front_id,
                                     got.front_qty, got.front_side);
                        end
                    end
                end
                wait_n = full_rate ? 0 : $urandom_range(0, 4);
                // one long hold-off to back the block up into its input
                if (reports_seen == HOLD_AT) wait_n = LONG_HOLD;
            end
            if (rx_wait != 0) begin
                m_ready <= 1'b0;
                rx_wait <= rx_wait - 1;
            end else if (wait_n != 0) begin
                m_ready <= 1'b0;
                rx_wait <= wait_n - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : run_phases
        logic [DATA_W-1:0] lp;
        order_item_t       it;
        int                add_pct;
        int                rem_pct;
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty level, every reject but a full queue, total at its limit, duplicates
        write_level_price(32'd1);
        push_order(plof_pkg::OP_REDUCE, 32'd0, 1'b0, 1'b0, 32'd0, 32'd5);
        push_order(plof_pkg::OP_REMOVE, 32'd7, 1'b0, 1'b0, 32'd0, 32'd0);
        push_order(plof_pkg::OP_NONE, ALL_ONES, 1'b1, 1'b1, ALL_ONES, ALL_ONES);
        push_order(plof_pkg::OP_ADD, 32'd1, 1'b0, 1'b0, 32'd1, 32'd10);
        push_order(plof_pkg::OP_ADD, 32'd1, 1'b0, 1'b1, 32'd1, 32'd0);
        push_order(plof_pkg::OP_ADD, 32'd1, 1'b0, 1'b1, 32'd2, 32'd10);
        push_order(plof_pkg::OP_ADD, ALL_ONES, 1'b1, 1'b1, 32'd1, 32'd100);
        push_order(plof_pkg::OP_ADD, 32'd0, 1'b0, 1'b1, 32'd1, ALL_ONES);
        push_order(plof_pkg::OP_ADD, 32'd0, 1'b0, 1'b1, 32'd1, ALL_ONES - 32'd100);
        push_order(plof_pkg::OP_ADD, 32'd2, 1'b1, 1'b1, 32'd1, 32'd1);
        push_order(plof_pkg::OP_REDUCE, 32'd0, 1'b0, 1'b0, 32'd0, 32'd101);
        push_order(plof_pkg::OP_REDUCE, 32'd0, 1'b0, 1'b0, 32'd0, 32'd100);
        push_order(plof_pkg::OP_REDUCE, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0);
        push_order(plof_pkg::OP_ADD, ALL_ONES, 1'b0, 1'b1, 32'd1, 32'd5);
        push_order(plof_pkg::OP_REMOVE, ALL_ONES, 1'b0, 1'b0, 32'd0, 32'd0);
        push_order(plof_pkg::OP_REMOVE, 32'd12345, 1'b0, 1'b0, 32'd0, 32'd0);
        push_order(plof_pkg::OP_REMOVE, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0);
        push_order(plof_pkg::OP_REMOVE, ALL_ONES, 1'b0, 1'b0, 32'd0, 32'd0);
        push_order(plof_pkg::OP_REDUCE, 32'd0, 1'b0, 1'b0, 32'd0, ALL_ONES);
        wait_drained();

        // Top level price, then fill the queue past its depth
        write_level_price(ALL_ONES);
        push_order(plof_pkg::OP_ADD, 32'd9, 1'b1, 1'b1, 32'd1, 32'd3);
        for (int k = 0; k < FILL_ADDS; k++)
            push_order(plof_pkg::OP_ADD, $urandom, 1'($urandom_range(0, 1)), 1'b1,
                       ALL_ONES, $urandom_range(1, 100));
        wait_drained();

        // Zero level price rejects every add, even at price zero
        write_level_price('0);
        push_order(plof_pkg::OP_ADD, 32'd3, 1'b0, 1'b1, 32'd0, 32'd5);
        push_order(plof_pkg::OP_ADD, 32'd3, 1'b1, 1'b1, ALL_ONES, 32'd5);
        push_order(plof_pkg::OP_REDUCE, 32'd0, 1'b0, 1'b0, 32'd0, 32'd1);
        wait_drained();

        // Random phases: alternate filling and draining mixes
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       lp = 32'd1;
                2:       lp = ALL_ONES;
                3:       lp = $urandom_range(1, 8);
                4:       lp = '0;
                default: lp = $urandom;
            endcase
            write_level_price(lp);
            full_rate = (p == 2 || p == 5);
            add_pct   = (p % 2 == 0) ? 60 : 25;
            rem_pct   = (p % 2 == 0) ? 15 : 35;
            for (int h = 0; h < 2; h++) begin
                for (int k = 0; k < HALF_PHASE; k++) begin
                    it = make_random_order(add_pct, rem_pct);
                    pending_orders.insert(pending_orders.size(), it);
                end
                wait_drained();
            end
        end
        full_rate = 1'b0;
        wait_drained();

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- price_level_order_fifo_top.f -----
hdl/plof_pkg.sv
hdl/plof_cell.sv
hdl/price_level_order_fifo_top.sv
verif/tb_price_level_order_fifo_top.sv
